FILE: hdl/tpwq_pkg.sv
// shared types, codes and constants of the thread pool priority wait queue
package tpwq_pkg;

  localparam int SLOT_COUNT_DEF    = 8;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int ID_W              = 4;
  localparam int PRIO_REQ_W        = 8;

  typedef logic [ID_W-1:0] slot_t;

  localparam slot_t SLOT_NIL = 4'hF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_SUSPEND = 2'd1,
    OP_RESUME  = 2'd2,
    OP_FREE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_BUSY    = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PLACE_FREE = 2'd0,
    PLACE_WAIT = 2'd1,
    PLACE_RUN  = 2'd2
  } place_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [ID_W-1:0]       thread_id;
    logic [PRIO_REQ_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] given_id;
    logic            running_valid;
    logic [ID_W-1:0] running_id;
  } rsp_t;

  // datapath micro-operations, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_ERR_NO_SLOT,
    DP_ERR_BUSY,
    DP_ERR_BAD,
    DP_TAKE_FREE,
    DP_TAKE_RUN,
    DP_TAKE_RESUME,
    DP_TAKE_RELEASE,
    DP_UNL_RD,
    DP_UNL_WR,
    DP_PUSH_A,
    DP_PUSH_B,
    DP_RD_HEAD,
    DP_RD_NEXT,
    DP_RD_WAKE,
    DP_WALK_STEP,
    DP_INS_A,
    DP_INS_B,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UNL_RD,
    S_UNL_WR,
    S_PUSH_A,
    S_PUSH_B,
    S_SUS_HEAD,
    S_SUS_CMP,
    S_WALK_N,
    S_WALK_W,
    S_INS_A,
    S_INS_B,
    S_DONE
  } fsm_t;

  // datapath flags seen by the controller
  typedef struct packed {
    op_t    op;
    logic   free_ok;
    logic   wait_ok;
    logic   run_ok;
    logic   tid_ok;
    place_t tid_place;
    logic   next_ok;
    logic   wake_gt;
    logic   cnt_last;
  } dp_stat_t;

endpackage

FILE: hdl/tpwq_datapath.sv
// link memories, list heads, running register and walk registers
module tpwq_datapath #(
  parameter int SLOT_COUNT    = tpwq_pkg::SLOT_COUNT_DEF,
  parameter int PRIORITY_BITS = tpwq_pkg::PRIORITY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tpwq_pkg::req_t     req,
  input  tpwq_pkg::dp_op_t   cmd,
  output tpwq_pkg::dp_stat_t stat,
  output tpwq_pkg::rsp_t     rsp
);
  import tpwq_pkg::*;

  localparam int    SLOT_W     = $clog2(SLOT_COUNT);
  localparam slot_t SLOT_LIMIT = slot_t'(SLOT_COUNT);

  typedef logic [PRIORITY_BITS-1:0] wake_t;

  function automatic logic slot_ok(input slot_t x);
    return x < SLOT_LIMIT;
  endfunction

  function automatic slot_t next_init(input logic [SLOT_W-1:0] idx);
    return (idx == SLOT_W'(SLOT_COUNT - 1)) ? SLOT_NIL : slot_t'(idx) + slot_t'(1);
  endfunction

  function automatic slot_t prev_init(input logic [SLOT_W-1:0] idx);
    return (idx == '0) ? SLOT_NIL : slot_t'(idx) - slot_t'(1);
  endfunction

  // list heads and running thread
  slot_t free_head, free_head_next;
  slot_t wait_head, wait_head_next;
  slot_t running, running_next;

  // per-item registers
  op_t     op_r, op_next;
  slot_t   tid_r, tid_next;
  wake_t   v_r, v_next;
  slot_t   s_r, s_next;
  slot_t   p_r, p_next;
  logic [SLOT_W-1:0] cnt, cnt_next;
  status_t status_r, status_next;
  slot_t   given_r, given_next;
  rsp_t    rsp_q, rsp_next;

  // memories and their ports
  slot_t next_mem [SLOT_COUNT];
  slot_t prev_mem [SLOT_COUNT];
  wake_t wake_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] next_vld;
  logic [SLOT_COUNT-1:0] prev_vld;
  place_t place [SLOT_COUNT];

  logic  next_we, prev_we, wake_we, place_we;
  slot_t next_wa, prev_wa, wake_wa, place_wa;
  slot_t next_wd, prev_wd;
  wake_t wake_wd;
  place_t place_wd;
  logic  next_re, prev_re, wake_re;
  slot_t next_ra, prev_ra, wake_ra;
  slot_t next_rd, prev_rd;
  wake_t wake_rd;

  logic [SLOT_W-1:0] next_wi, prev_wi, wake_wi, place_wi;
  logic [SLOT_W-1:0] next_ri, prev_ri, wake_ri, tid_i, run_i, free_i;

  wake_t req_wake;
  logic  push_free;
  slot_t push_head;
  wake_t push_wake;

  assign next_wi  = next_wa[SLOT_W-1:0];
  assign prev_wi  = prev_wa[SLOT_W-1:0];
  assign wake_wi  = wake_wa[SLOT_W-1:0];
  assign place_wi = place_wa[SLOT_W-1:0];
  assign next_ri  = next_ra[SLOT_W-1:0];
  assign prev_ri  = prev_ra[SLOT_W-1:0];
  assign wake_ri  = wake_ra[SLOT_W-1:0];
  assign tid_i    = tid_r[SLOT_W-1:0];
  assign run_i    = running[SLOT_W-1:0];
  assign free_i   = free_head[SLOT_W-1:0];

  // the request priority is zero-extended to the wake width, or cut to its low wake bits
  if (PRIORITY_BITS > PRIO_REQ_W) begin : g_wide
    assign req_wake = {{(PRIORITY_BITS - PRIO_REQ_W){1'b0}}, req.priority_req};
  end else begin : g_narrow
    assign req_wake = req.priority_req[PRIORITY_BITS-1:0];
  end

  assign push_free = (op_r == OP_FREE);
  assign push_head = push_free ? free_head : wait_head;
  assign push_wake = (op_r == OP_SUSPEND) ? v_r : '0;

  always_comb begin
    free_head_next = free_head;
    wait_head_next = wait_head;
    running_next   = running;
    op_next        = op_r;
    tid_next       = tid_r;
    v_next         = v_r;
    s_next         = s_r;
    p_next         = p_r;
    cnt_next       = cnt;
    status_next    = status_r;
    given_next     = given_r;
    next_we  = 1'b0;  next_wa  = s_r;  next_wd = SLOT_NIL;
    prev_we  = 1'b0;  prev_wa  = s_r;  prev_wd = SLOT_NIL;
    wake_we  = 1'b0;  wake_wa  = s_r;  wake_wd = push_wake;
    place_we = 1'b0;  place_wa = s_r;  place_wd = PLACE_WAIT;
    next_re  = 1'b0;  next_ra  = s_r;
    prev_re  = 1'b0;  prev_ra  = s_r;
    wake_re  = 1'b0;  wake_ra  = wait_head;
    unique case (cmd)
      DP_NOP: begin
      end
      DP_LOAD: begin
        op_next     = op_t'(req.operation);
        tid_next    = req.thread_id;
        v_next      = req_wake;
        status_next = ST_OK;
        given_next  = SLOT_NIL;
      end
      DP_ERR_NO_SLOT: status_next = ST_NO_SLOT;
      DP_ERR_BUSY:    status_next = ST_BUSY;
      DP_ERR_BAD:     status_next = ST_BAD;
      DP_TAKE_FREE: begin
        s_next     = free_head;
        given_next = free_head;
      end
      DP_TAKE_RUN: begin
        s_next       = running;
        running_next = SLOT_NIL;
        wake_we      = 1'b1;
        wake_wa      = running;
        wake_wd      = v_r;
        place_we     = 1'b1;
        place_wa     = running;
        place_wd     = PLACE_WAIT;
      end
      DP_TAKE_RESUME: begin
        s_next       = tid_r;
        running_next = tid_r;
        place_we     = 1'b1;
        place_wa     = tid_r;
        place_wd     = PLACE_RUN;
      end
      DP_TAKE_RELEASE: begin
        s_next = tid_r;
        if (running == tid_r) begin
          running_next = SLOT_NIL;
        end
      end
      DP_UNL_RD: begin
        next_re = 1'b1;
        prev_re = 1'b1;
      end
      DP_UNL_WR: begin
        // bridge the neighbours, or move the head past the slot
        if (slot_ok(next_rd)) begin
          prev_we = 1'b1;
          prev_wa = next_rd;
          prev_wd = prev_rd;
        end
        if (slot_ok(prev_rd)) begin
          next_we = 1'b1;
          next_wa = prev_rd;
          next_wd = next_rd;
        end else if (op_r == OP_ALLOC) begin
          if (free_head == s_r) begin
            free_head_next = next_rd;
          end
        end else if (wait_head == s_r) begin
          wait_head_next = next_rd;
        end
      end
      DP_PUSH_A: begin
        next_we = 1'b1;
        next_wd = push_head;
        if (slot_ok(push_head)) begin
          prev_we = 1'b1;
          prev_wa = push_head;
          prev_wd = s_r;
        end
        if (push_free) begin
          free_head_next = s_r;
        end else begin
          wait_head_next = s_r;
        end
        wake_we  = 1'b1;
        place_we = 1'b1;
        place_wd = push_free ? PLACE_FREE : PLACE_WAIT;
      end
      DP_PUSH_B: begin
        prev_we = 1'b1;
      end
      DP_RD_HEAD: begin
        wake_re  = 1'b1;
        p_next   = wait_head;
        cnt_next = '0;
      end
      DP_RD_NEXT: begin
        next_re = 1'b1;
        next_ra = p_r;
      end
      DP_RD_WAKE: begin
        wake_re = 1'b1;
        wake_ra = next_rd;
      end
      DP_WALK_STEP: begin
        p_next   = next_rd;
        cnt_next = cnt + SLOT_W'(1);
        next_re  = 1'b1;
        next_ra  = next_rd;
      end
      DP_INS_A: begin
        next_we = 1'b1;
        next_wd = next_rd;
        prev_we = 1'b1;
        prev_wd = p_r;
      end
      DP_INS_B: begin
        next_we = 1'b1;
        next_wa = p_r;
        next_wd = s_r;
        if (slot_ok(next_rd)) begin
          prev_we = 1'b1;
          prev_wa = next_rd;
          prev_wd = s_r;
        end
      end
      DP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_next.status        = status_r;
    rsp_next.given_id      = given_r;
    rsp_next.running_valid = slot_ok(running);
    rsp_next.running_id    = slot_ok(running) ? running : SLOT_NIL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      wait_head <= SLOT_NIL;
      running   <= SLOT_NIL;
    end else begin
      free_head <= free_head_next;
      wait_head <= wait_head_next;
      running   <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_next;
    tid_r    <= tid_next;
    v_r      <= v_next;
    s_r      <= s_next;
    p_r      <= p_next;
    cnt      <= cnt_next;
    status_r <= status_next;
    given_r  <= given_next;
    if (cmd == DP_EMIT) begin
      rsp_q <= rsp_next;
    end
  end

  // written flags, unwritten entries read as the reset links
  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
      prev_vld <= '0;
    end else begin
      if (next_we) begin
        next_vld[next_wi] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld[prev_wi] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wi] <= next_wd;
    end
    if (next_re) begin
      next_rd <= next_vld[next_ri] ? next_mem[next_ri] : next_init(next_ri);
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wi] <= prev_wd;
    end
    if (prev_re) begin
      prev_rd <= prev_vld[prev_ri] ? prev_mem[prev_ri] : prev_init(prev_ri);
    end
  end

  always_ff @(posedge clk) begin
    if (wake_we) begin
      wake_mem[wake_wi] <= wake_wd;
    end
    if (wake_re) begin
      wake_rd <= wake_mem[wake_ri];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        place[i] <= PLACE_FREE;
      end
    end else if (place_we) begin
      place[place_wi] <= place_wd;
    end
  end

  assign stat.op        = op_r;
  assign stat.free_ok   = slot_ok(free_head);
  assign stat.wait_ok   = slot_ok(wait_head);
  assign stat.run_ok    = slot_ok(running);
  assign stat.tid_ok    = slot_ok(tid_r);
  assign stat.tid_place = slot_ok(tid_r) ? place[tid_i] : PLACE_FREE;
  assign stat.next_ok   = slot_ok(next_rd);
  assign stat.wake_gt   = wake_rd > v_r;
  assign stat.cnt_last  = (cnt == SLOT_W'(SLOT_COUNT - 1));

  assign rsp = rsp_q;

  // between items the lists and running slot are consistent
  a_run_place: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_LOAD && stat.run_ok) |-> place[run_i] == PLACE_RUN)
    else $error("running slot not tagged running");

  a_free_place: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_LOAD && stat.free_ok) |-> place[free_i] == PLACE_FREE)
    else $error("free list head not tagged free");

  a_run_not_queued: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_LOAD && stat.run_ok && stat.wait_ok) |-> wait_head != running)
    else $error("running slot at wait queue head");

endmodule

FILE: hdl/tpwq_ctrl.sv
// sequencer for allocate, suspend, resume and free
module tpwq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  tpwq_pkg::dp_stat_t stat,
  output tpwq_pkg::dp_op_t   cmd
);
  import tpwq_pkg::*;

  fsm_t state, state_next;
  logic rsp_valid_next;
  logic out_free;
  logic resume_bad;
  logic release_bad;

  assign out_free    = !rsp_valid || !rsp_stall;
  assign resume_bad  = !stat.tid_ok || stat.tid_place != PLACE_WAIT;
  assign release_bad = !stat.tid_ok || stat.tid_place == PLACE_FREE;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (req_valid) state_next = S_CHECK;
      S_CHECK: begin
        unique case (stat.op)
          OP_ALLOC:   state_next = stat.free_ok ? S_UNL_RD : S_DONE;
          OP_SUSPEND: state_next = !stat.run_ok ? S_DONE :
                                   (stat.wait_ok ? S_SUS_HEAD : S_PUSH_A);
          OP_RESUME:  state_next = (stat.run_ok || resume_bad) ? S_DONE : S_UNL_RD;
          OP_FREE:    state_next = release_bad ? S_DONE :
                                   (stat.tid_place == PLACE_WAIT ? S_UNL_RD : S_PUSH_A);
          default:    state_next = S_DONE;
        endcase
      end
      S_UNL_RD:   state_next = S_UNL_WR;
      S_UNL_WR:   state_next = (stat.op == OP_RESUME) ? S_DONE : S_PUSH_A;
      S_PUSH_A:   state_next = S_PUSH_B;
      S_PUSH_B:   state_next = S_DONE;
      S_SUS_HEAD: state_next = S_SUS_CMP;
      S_SUS_CMP:  state_next = stat.wake_gt ? S_PUSH_A : S_WALK_N;
      S_WALK_N:   state_next = stat.next_ok ? S_WALK_W : S_INS_A;
      S_WALK_W:   state_next = (stat.wake_gt || stat.cnt_last) ? S_INS_A : S_WALK_N;
      S_INS_A:    state_next = S_INS_B;
      S_INS_B:    state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = DP_NOP;
    unique case (state)
      S_IDLE:     if (req_valid) cmd = DP_LOAD;
      S_CHECK: begin
        unique case (stat.op)
          OP_ALLOC:   cmd = stat.free_ok ? DP_TAKE_FREE : DP_ERR_NO_SLOT;
          OP_SUSPEND: cmd = stat.run_ok ? DP_TAKE_RUN : DP_ERR_BAD;
          OP_RESUME:  cmd = stat.run_ok ? DP_ERR_BUSY :
                            (resume_bad ? DP_ERR_BAD : DP_TAKE_RESUME);
          OP_FREE:    cmd = release_bad ? DP_ERR_BAD : DP_TAKE_RELEASE;
          default:    cmd = DP_NOP;
        endcase
      end
      S_UNL_RD:   cmd = DP_UNL_RD;
      S_UNL_WR:   cmd = DP_UNL_WR;
      S_PUSH_A:   cmd = DP_PUSH_A;
      S_PUSH_B:   cmd = DP_PUSH_B;
      S_SUS_HEAD: cmd = DP_RD_HEAD;
      S_SUS_CMP:  cmd = stat.wake_gt ? DP_NOP : DP_RD_NEXT;
      S_WALK_N:   cmd = stat.next_ok ? DP_RD_WAKE : DP_NOP;
      S_WALK_W:   cmd = stat.wake_gt ? DP_NOP : DP_WALK_STEP;
      S_INS_A:    cmd = DP_INS_A;
      S_INS_B:    cmd = DP_INS_B;
      S_DONE:     if (out_free) cmd = DP_EMIT;
      default:    cmd = DP_NOP;
    endcase
  end

  assign req_stall      = (state != S_IDLE);
  assign rsp_valid_next = (cmd == DP_EMIT) || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (rsp_valid && state == S_IDLE))
    else $error("finished item not presented");

endmodule

FILE: hdl/thread_pool_priority_wait_queue_top.sv
// thread pool priority wait queue: free list, sorted wait queue and running slot
// a rejected item goes straight to its result; resume unlinks, free of the running
//   slot pushes, allocate and free of a waiting slot unlink and push, and suspend
//   runs the sorted-insert walk (two reads per slot) when the wait queue is not empty
// throughput: one item at a time; the next item is taken the cycle after the
//   result is registered, while that result may still be waiting on rsp_stall
// reset: synchronous; lists return to their initial links at once, no clearing pass
module thread_pool_priority_wait_queue_top #(
  parameter int SLOT_COUNT    = tpwq_pkg::SLOT_COUNT_DEF,
  parameter int PRIORITY_BITS = tpwq_pkg::PRIORITY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tpwq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tpwq_pkg::rsp_t rsp
);
  import tpwq_pkg::*;

  // command from the sequencer, flags back from the datapath
  dp_op_t   cmd;
  dp_stat_t stat;

  // controller: decides the operation and steps through unlink, push and
  // sorted insert, one micro-operation a cycle; also owns the result valid
  tpwq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: link memories with written flags, place tags, heads,
  // running register, walk pointer and the registered result item
  tpwq_datapath #(
    .SLOT_COUNT    (SLOT_COUNT),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

FILE: tb/tb.sv
// self-checking testbench for the thread pool priority wait queue
module tb;
  import tpwq_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int PRIO_BITS = PRIORITY_BITS_DEF;
  localparam logic [7:0] PRIO_MASK = (PRIO_BITS >= 8) ? 8'hFF : 8'((1 << PRIO_BITS) - 1);
  localparam int RANDOM_ITEMS = 1625;
  localparam int HOLD_AFTER_ITEMS = 500;
  localparam int HOLD_CYCLES = 400;

  // one row of the directed stimulus, with a typed-in reply where it is obvious
  typedef struct packed {
    req_t stim;
    bit   typed;
    rsp_t want;
  } drill_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // mirror of the pool state, updated as each item is taken
  slot_t      link_next [SLOTS];
  slot_t      link_prev [SLOTS];
  logic [7:0] wake [SLOTS];
  place_t     place_of [SLOTS];
  slot_t      free_top;
  slot_t      queue_top;
  slot_t      current;

  rsp_t awaited_rsp [$];
  int   mismatches = 0;
  int   replies_seen = 0;
  int   items_taken = 0;
  bit   sender_calm = 1'b0;
  bit   receiver_calm = 1'b0;

  thread_pool_priority_wait_queue_top #(
    .SLOT_COUNT   (SLOTS),
    .PRIORITY_BITS(PRIO_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------- pool model

  function automatic void clear_pool();
    for (int i = 0; i < SLOTS; i++) begin
      link_next[i] = (i == SLOTS - 1) ? SLOT_NIL : slot_t'(i + 1);
      link_prev[i] = (i == 0) ? SLOT_NIL : slot_t'(i - 1);
      wake[i] = '0;
      place_of[i] = PLACE_FREE;
    end
    free_top = '0;
    queue_top = SLOT_NIL;
    current = SLOT_NIL;
  endfunction

  // take a slot out of the free list or the wait queue
  function automatic void unlink_slot(slot_t s, bit from_free);
    slot_t n = link_next[s];
    slot_t p = link_prev[s];
    if (n < SLOTS) link_prev[n] = p;
    if (p < SLOTS) link_next[p] = n;
    else if (from_free && free_top == s) free_top = n;
    else if (!from_free && queue_top == s) queue_top = n;
    link_next[s] = SLOT_NIL;
    link_prev[s] = SLOT_NIL;
  endfunction

  function automatic void push_slot(slot_t s, bit onto_free);
    slot_t h = onto_free ? free_top : queue_top;
    link_next[s] = h;
    link_prev[s] = SLOT_NIL;
    if (h < SLOTS) link_prev[h] = s;
    if (onto_free) free_top = s;
    else queue_top = s;
  endfunction

  // sorted insert, ties go behind the values already queued
  function automatic void insert_sorted(slot_t s, logic [7:0] v);
    slot_t p;
    slot_t n;
    bit    stop = 1'b0;
    wake[s] = v;
    if (queue_top >= SLOTS || wake[queue_top] > v) begin
      push_slot(s, 1'b0);
      return;
    end
    p = queue_top;
    for (int k = 0; k < SLOTS && !stop; k++) begin
      n = link_next[p];
      if (n >= SLOTS || wake[n] > v) stop = 1'b1;
      else p = n;
    end
    n = link_next[p];
    link_next[s] = n;
    link_prev[s] = p;
    link_next[p] = s;
    if (n < SLOTS) link_prev[n] = s;
  endfunction

  function automatic rsp_t apply_pool_op(req_t it);
    rsp_t       r;
    slot_t      s;
    slot_t      tid = it.thread_id;
    logic [7:0] pr = it.priority_req & PRIO_MASK;
    r.status = ST_OK;
    r.given_id = SLOT_NIL;
    case (it.operation)
      OP_ALLOC: begin
        s = free_top;
        if (s >= SLOTS) begin
          r.status = ST_NO_SLOT;
        end else begin
          unlink_slot(s, 1'b1);
          wake[s] = '0;
          push_slot(s, 1'b0);
          place_of[s] = PLACE_WAIT;
          r.given_id = s;
        end
      end
      OP_SUSPEND: begin
        if (current >= SLOTS) begin
          r.status = ST_BAD;
        end else begin
          insert_sorted(current, pr);
          place_of[current] = PLACE_WAIT;
          current = SLOT_NIL;
        end
      end
      OP_RESUME: begin
        if (current < SLOTS) begin
          r.status = ST_BUSY;
        end else if (tid >= SLOTS || place_of[tid] != PLACE_WAIT) begin
          r.status = ST_BAD;
        end else begin
          unlink_slot(tid, 1'b0);
          place_of[tid] = PLACE_RUN;
          current = tid;
        end
      end
      default: begin
        if (tid >= SLOTS || place_of[tid] == PLACE_FREE) begin
          r.status = ST_BAD;
        end else begin
          if (place_of[tid] == PLACE_WAIT) unlink_slot(tid, 1'b0);
          if (current == tid) current = SLOT_NIL;
          wake[tid] = '0;
          push_slot(tid, 1'b1);
          place_of[tid] = PLACE_FREE;
        end
      end
    endcase
    r.running_valid = (current < SLOTS);
    r.running_id = (current < SLOTS) ? current : SLOT_NIL;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic drill_row_t row(op_t op, int tid, int prio, bit typed = 1'b0,
                                     status_t st = ST_OK, int gid = 15, int rid = 15);
    drill_row_t d;
    d.stim.operation = op;
    d.stim.thread_id = slot_t'(tid);
    d.stim.priority_req = 8'(prio);
    d.typed = typed;
    d.want.status = st;
    d.want.given_id = slot_t'(gid);
    d.want.running_valid = (rid != 15);
    d.want.running_id = slot_t'(rid);
    return d;
  endfunction

  // mostly zero, sometimes short, rarely a long gap; none in calm stretches
  function automatic int pick_gap(bit calm);
    int r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // builds the next random item from the current pool state: mostly legal
  // operations with random content, the rest plain noise
  function automatic req_t shape_item();
    req_t  it;
    slot_t waiting [$];
    slot_t held [$];
    int    pick;
    it.operation = 2'($urandom_range(0, 3));
    it.thread_id = 4'($urandom_range(0, 15));
    it.priority_req = 8'($urandom);
    if ($urandom_range(0, 99) < 15) return it;
    for (int i = 0; i < SLOTS; i++) begin
      if (place_of[i] == PLACE_WAIT) waiting.push_back(slot_t'(i));
      if (place_of[i] != PLACE_FREE) held.push_back(slot_t'(i));
    end
    // wake values: extremes, ties with queued threads and small clusters
    case ($urandom_range(0, 9))
      0, 1: it.priority_req = 8'h00;
      2, 3: it.priority_req = 8'hFF;
      4, 5, 6: if (waiting.size() > 0)
        it.priority_req = wake[waiting[$urandom_range(0, waiting.size() - 1)]];
      7: it.priority_req = 8'($urandom_range(0, 3));
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.operation = OP_ALLOC;
    end else if (pick < 80) begin
      if (current != SLOT_NIL) begin
        it.operation = OP_SUSPEND;
      end else if (waiting.size() > 0) begin
        it.operation = OP_RESUME;
        it.thread_id = ($urandom_range(0, 9) < 6) ? queue_top :
                       waiting[$urandom_range(0, waiting.size() - 1)];
      end else begin
        it.operation = OP_ALLOC;
      end
    end else if (held.size() > 0) begin
      it.operation = OP_FREE;
      it.thread_id = (current != SLOT_NIL && $urandom_range(0, 1)) ? current :
                     held[$urandom_range(0, held.size() - 1)];
    end else begin
      it.operation = OP_ALLOC;
    end
    return it;
  endfunction

  // offers one item, holds it until taken, then records its expected reply
  task automatic offer(req_t item, bit typed, rsp_t typed_rsp);
    int   gap;
    rsp_t predicted;
    if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    items_taken++;
    predicted = apply_pool_op(item);
    awaited_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  initial begin : stimulus
    drill_row_t drill [$];
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    clear_pool();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // rejections straight after reset
    drill.push_back(row(OP_RESUME, 0, 0, 1'b1, ST_BAD, 15, 15));
    drill.push_back(row(OP_FREE, 0, 0, 1'b1, ST_BAD, 15, 15));
    drill.push_back(row(OP_SUSPEND, 0, 0, 1'b1, ST_BAD, 15, 15));
    // allocate ignores the other fields
    drill.push_back(row(OP_ALLOC, 0, 0, 1'b1, ST_OK, 0, 15));
    drill.push_back(row(OP_ALLOC, 15, 255, 1'b1, ST_OK, 1, 15));
    // out-of-range slot, then resume, then resume while busy
    drill.push_back(row(OP_RESUME, 15, 0, 1'b1, ST_BAD, 15, 15));
    drill.push_back(row(OP_RESUME, 0, 0, 1'b1, ST_OK, 15, 0));
    drill.push_back(row(OP_RESUME, 1, 0, 1'b1, ST_BUSY, 15, 0));
    drill.push_back(row(OP_ALLOC, 0, 0, 1'b1, ST_OK, 2, 0));
    // sorted inserts: at the tail, in the middle, in front of the head
    drill.push_back(row(OP_SUSPEND, 0, 255));
    drill.push_back(row(OP_RESUME, 2, 0));
    drill.push_back(row(OP_SUSPEND, 0, 128));
    drill.push_back(row(OP_RESUME, 1, 0));
    drill.push_back(row(OP_SUSPEND, 0, 5));
    drill.push_back(row(OP_RESUME, 2, 0));
    // free a waiting slot while another thread keeps running, then a sorted insert on a tie
    drill.push_back(row(OP_FREE, 0, 0));
    drill.push_back(row(OP_SUSPEND, 0, 5));
    drill.push_back(row(OP_RESUME, 2, 0));
    // freeing the running slot leaves nothing running
    drill.push_back(row(OP_FREE, 2, 0, 1'b1, ST_OK, 15, 15));
    // drain the free list, then one allocate too many
    repeat (SLOTS - 1) drill.push_back(row(OP_ALLOC, 0, 0));
    drill.push_back(row(OP_ALLOC, 0, 0, 1'b1, ST_NO_SLOT, 15, 15));

    foreach (drill[k]) offer(drill[k].stim, drill[k].typed, drill[k].want);
    repeat (RANDOM_ITEMS) offer(shape_item(), 1'b0, '0);
    req_valid <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    // let any stray reply show up before the verdict
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("thread_pool_priority_wait_queue_top test passed");
    end else begin
      $display("thread_pool_priority_wait_queue_top test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // random back-pressure, with one long hold-off so the block fills and
  // stalls its input while items keep being offered
  initial begin : receiver
    int  span;
    bit  held_long = 1'b0;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      if (!held_long && items_taken >= HOLD_AFTER_ITEMS) begin
        held_long = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = pick_gap(receiver_calm);
        if (span > 0) begin
          rsp_stall <= 1'b1;
          repeat (span) @(posedge clk);
        end
      end
      rsp_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("reply %0d: %s is %0d, predicted %0d", replies_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_replies
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      replies_seen++;
      if (awaited_rsp.size() == 0) begin
        flag_mismatch("reply with nothing outstanding, status", 8'(rsp.status), 8'd0);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch("status", 8'(rsp.status), 8'(want.status));
        if (rsp.given_id !== want.given_id)
          flag_mismatch("given_id", 8'(rsp.given_id), 8'(want.given_id));
        if (rsp.running_valid !== want.running_valid)
          flag_mismatch("running_valid", 8'(rsp.running_valid), 8'(want.running_valid));
        if (rsp.running_id !== want.running_id)
          flag_mismatch("running_id", 8'(rsp.running_id), 8'(want.running_id));
      end
    end
  end

  // hang guard
  initial begin : watchdog
    #2000000;
    $display("thread_pool_priority_wait_queue_top test failed");
    $finish;
  end

endmodule
